>>> hdl/ttma_pkg.sv
// Package for the task table merge and aging block.
// Holds the entry and result layouts, item kind codes, register indexes and
// the fixed arithmetic constants. No dependencies.
package ttma_pkg;

	// Item kinds carried in tuser of the input stream.
	typedef enum logic [1:0] {
		KIND_SIGHT  = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	// Configuration register indexes (byte address 4*index).
	localparam int          APB_AW           = 4;
	localparam logic [1:0]  REG_FORGET_RATE  = 2'd0;
	localparam logic [1:0]  REG_EXPIRE_LIMIT = 2'd1;
	localparam logic [1:0]  REG_DIST_CREEP   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [15:0] FORGET_RATE_RST  = 16'd256;
	localparam logic [15:0] EXPIRE_LIMIT_RST = 16'd100;
	localparam logic [7:0]  DIST_CREEP_RST   = 8'd4;

	// Hop cost is HOP_UNIT*range/RANGE_SCALE. The division uses a rounded-up
	// reciprocal scaled by 2^HOP_RECIP_SHIFT, exact for all 8-bit ranges.
	localparam logic [11:0] HOP_UNIT        = 12'd15;
	localparam int          RANGE_SCALE     = 130;
	localparam int          HOP_RECIP_SHIFT = 20;
	localparam logic [12:0] HOP_RECIP =
		13'((2 ** HOP_RECIP_SHIFT + RANGE_SCALE - 1) / RANGE_SCALE);

	localparam logic [7:0]  DIST_MAX    = 8'd255;
	localparam logic [7:0]  DIST_DIRECT = 8'd1;

	// Freshness: ((gap >> FRESH_SHIFT) * rate) >> RATE_FRAC.
	localparam int FRESH_SHIFT = 5;
	localparam int RATE_FRAC   = 8;
	localparam int GAP_W       = 32 - FRESH_SHIFT;
	localparam int PROD_W      = GAP_W + 16;
	localparam int FRESH_W     = PROD_W - RATE_FRAC;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [15:0] fresh;
		logic [31:0] stamp;
		logic [7:0]  need;
		logic [7:0]  hops;
		logic [7:0]  key;
	} entry_t;

	// Result transfer layout, lowest field in the lowest bits.
	typedef struct packed {
		logic [5:0] pad;
		logic [3:0] task_count;
		logic       table_full;
		logic       info_changed;
		logic       was_inserted;
		logic [2:0] entry_slot;
	} res_t;

endpackage

>>> hdl/ttma_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the task table storage. No dependencies.
module ttma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read share the clock.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/task_table_merge_and_aging.sv
// Top level of the task table merge and aging block.
// Depends on ttma_pkg and instantiates ttma_ram for the entry storage.
//
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid/s_tready          s_tdata (fields), s_tuser (kind)
// m_*       out        m_tvalid/m_tready          m_tdata (result fields)
// APB       in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item is handled at a time; the table memory has a single read port, so
// every item walks the valid entries one slot per cycle.
// A sighting or report walks up to the matched slot or to the end of the table;
// an aging tick walks every valid slot (read, multiply, write back).
// The finished result sits in the output register, and the next item is
// accepted as soon as it is loaded there, whether or not it has been taken.
// Reset clears the task count and control state; the memory is not cleared,
// as only slots below the task count are ever read.
module task_table_merge_and_aging import ttma_pkg::*; #(
	parameter int MAX_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	// [7:0] task_key, [15:8] reported_distance, [23:16] task_need,
	// [31:24] neighbour_range, [63:32] now_ticks
	input  logic [63:0]       s_tdata,
	// [1:0] kind
	input  logic [1:0]        s_tuser,
	// Result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// [2:0] entry_slot, [3] was_inserted, [4] info_changed, [5] table_full,
	// [9:6] task_count, [15:10] zero
	output logic [15:0]       m_tdata,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_RESP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_addr_q;

	// Captured item
	logic [1:0]         kind_q;
	logic [7:0]         key_q;
	logic [7:0]         need_q;
	logic [31:0]        now_q;
	logic [7:0]         newdist_q;

	// Result under construction and output register
	logic [SLOT_W-1:0]  res_slot_q;
	logic               res_ins_q;
	logic               res_chg_q;
	logic               res_full_q;
	res_t               res_out_q;
	logic               m_tvalid_q;

	// Configuration registers
	logic [15:0]        rate_q;
	logic [15:0]        limit_q;
	logic [7:0]         creep_q;

	// Read pipeline stage and aging stage
	logic               rd_v_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               age_v_s2;
	logic [SLOT_W-1:0]  slot_s2;
	entry_t             ent_s2;
	logic [PROD_W-1:0]  prod_s2;

	// Input field views
	logic [1:0]         kind_in;
	logic [7:0]         key_in;
	logic [7:0]         rdist_in;
	logic [7:0]         need_in;
	logic [7:0]         range_in;
	logic [31:0]        now_in;

	logic               in_xfer;
	logic               cfg_wr;
	logic               out_free;

	// Hop cost arithmetic
	logic [11:0]        hop_scaled;
	logic [24:0]        hop_recip_prod;
	logic [24-HOP_RECIP_SHIFT:0] hop_cost;
	logic [8:0]         rep_sum;
	logic [7:0]         rep_dist;

	// Memory access
	logic               rd_en;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	entry_t             ram_wentry;
	entry_t             new_entry;
	entry_t             aged_entry;

	// Scan decisions
	logic               key_hit;
	logic               update_hit;
	logic               scan_miss;
	logic               room;
	logic               insert;
	logic               age_we;
	logic               age_done;

	// Aging arithmetic
	logic [31:0]        stamp_gap;
	logic [FRESH_W-1:0] fresh_raw;
	logic [15:0]        fresh_clamped;
	logic [15:0]        aged_fresh;
	logic [8:0]         creep_sum;
	logic [7:0]         aged_dist;

	// Output field narrowing
	logic [SLOT_W+2:0]  slot_wide;
	logic [CNT_W+3:0]   cnt_wide;

	assign kind_in  = s_tuser;
	assign key_in   = s_tdata[7:0];
	assign rdist_in = s_tdata[15:8];
	assign need_in  = s_tdata[23:16];
	assign range_in = s_tdata[31:24];
	assign now_in   = s_tdata[63:32];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_out_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Reported distance plus hop cost, saturated.
	assign hop_scaled     = {4'b0, range_in} * HOP_UNIT;
	assign hop_recip_prod = {13'b0, hop_scaled} * {12'b0, HOP_RECIP};
	assign hop_cost       = hop_recip_prod[24:HOP_RECIP_SHIFT];
	assign rep_sum        = {1'b0, rdist_in} + 9'(hop_cost);
	assign rep_dist       = rep_sum[8] ? DIST_MAX : rep_sum[7:0];

	// Read issue: walk the valid slots in order.
	assign rd_en    = ((state_q == ST_SCAN) || (state_q == ST_AGE)) && (rd_addr_q < cnt_q);
	assign rd_entry = entry_t'(ram_rdata);

	// Key lookup: the first returned slot that matches wins.
	assign key_hit    = (state_q == ST_SCAN) && rd_v_s1 && (rd_entry.key == key_q);
	assign update_hit = key_hit &&
		((kind_q == KIND_SIGHT) || (rd_entry.hops > newdist_q));
	assign scan_miss  = (state_q == ST_SCAN) && !rd_v_s1 && (rd_addr_q >= cnt_q);
	assign room       = (cnt_q < CNT_W'(MAX_ENTRIES));
	assign insert     = scan_miss && room;

	// Freshness and distance update for the entry in the aging stage.
	assign stamp_gap     = now_q - rd_entry.stamp;
	assign fresh_raw     = prod_s2[PROD_W-1:RATE_FRAC];
	assign fresh_clamped = (fresh_raw > FRESH_W'(limit_q)) ? limit_q : fresh_raw[15:0];
	assign aged_fresh    = (ent_s2.fresh < limit_q) ? fresh_clamped : ent_s2.fresh;
	assign creep_sum     = {1'b0, ent_s2.hops} + {1'b0, creep_q};
	assign aged_dist     = (aged_fresh >= limit_q) ? DIST_MAX :
		(creep_sum[8] ? DIST_MAX : creep_sum[7:0]);
	assign age_we        = age_v_s2 && (ent_s2.hops != DIST_DIRECT);
	assign age_done      = (state_q == ST_AGE) && (rd_addr_q >= cnt_q) && !rd_v_s1 && !age_v_s2;

	always_comb begin
		aged_entry       = ent_s2;
		aged_entry.fresh = aged_fresh;
		aged_entry.hops  = aged_dist;
	end

	always_comb begin
		new_entry.fresh = '0;
		new_entry.stamp = now_q;
		new_entry.need  = need_q;
		new_entry.hops  = newdist_q;
		new_entry.key   = key_q;
	end

	// Memory write selection: aging write-back, refresh in place, or append.
	assign ram_we     = age_we || update_hit || insert;
	assign ram_waddr  = age_we ? slot_s2 : (key_hit ? slot_s1 : cnt_q[SLOT_W-1:0]);
	assign ram_wentry = age_we ? aged_entry : new_entry;

	ttma_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (rd_en),
		.raddr (rd_addr_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	// Read return tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			age_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= rd_en;
			age_v_s2 <= rd_v_s1 && (state_q == ST_AGE);
		end
	end

	// Aging stage payload: the multiply is registered before the clamp.
	always_ff @(posedge clk) begin
		slot_s1 <= rd_addr_q[SLOT_W-1:0];
		slot_s2 <= slot_s1;
		ent_s2  <= rd_entry;
		prod_s2 <= {16'b0, stamp_gap[31:FRESH_SHIFT]} * {GAP_W'(0), rate_q};
	end

	// Item sequencer, task count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rd_addr_q  <= '0;
			m_tvalid_q <= 1'b0;
			res_out_q  <= '0;
			res_slot_q <= '0;
			res_ins_q  <= 1'b0;
			res_chg_q  <= 1'b0;
			res_full_q <= 1'b0;
			kind_q     <= '0;
			key_q      <= '0;
			need_q     <= '0;
			now_q      <= '0;
			newdist_q  <= '0;
		end else begin
			// A taken result clears the output register unless a new one replaces it.
			if (m_tvalid_q && m_tready && (state_q != ST_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q     <= kind_in;
						key_q      <= key_in;
						need_q     <= need_in;
						now_q      <= now_in;
						newdist_q  <= (kind_in == KIND_REPORT) ? rep_dist : DIST_DIRECT;
						rd_addr_q  <= '0;
						res_slot_q <= '0;
						res_ins_q  <= 1'b0;
						res_chg_q  <= 1'b0;
						res_full_q <= 1'b0;
						case (kind_in)
							KIND_SIGHT, KIND_REPORT: state_q <= ST_SCAN;
							KIND_TICK:               state_q <= ST_AGE;
							default:                 state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCAN: begin
					if (key_hit) begin
						res_slot_q <= slot_s1;
						res_chg_q  <= update_hit;
						state_q    <= ST_RESP;
					end else if (scan_miss) begin
						if (room) begin
							res_slot_q <= cnt_q[SLOT_W-1:0];
							res_ins_q  <= 1'b1;
							res_chg_q  <= 1'b1;
							cnt_q      <= cnt_q + 1'b1;
						end else begin
							res_full_q <= 1'b1;
						end
						state_q <= ST_RESP;
					end
				end
				ST_AGE: begin
					if (age_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						res_out_q.pad          <= '0;
						res_out_q.task_count   <= cnt_wide[3:0];
						res_out_q.table_full   <= res_full_q;
						res_out_q.info_changed <= res_chg_q;
						res_out_q.was_inserted <= res_ins_q;
						res_out_q.entry_slot   <= slot_wide[2:0];
						m_tvalid_q             <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign slot_wide = {3'b0, res_slot_q};
	assign cnt_wide  = {4'b0, cnt_q};

	// Configuration registers, written on the access phase of a transfer.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= FORGET_RATE_RST;
			limit_q <= EXPIRE_LIMIT_RST;
			creep_q <= DIST_CREEP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FORGET_RATE:  rate_q  <= pwdata[15:0];
				REG_EXPIRE_LIMIT: limit_q <= pwdata[15:0];
				REG_DIST_CREEP:   creep_q <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_FORGET_RATE:  prdata = {16'b0, rate_q};
			REG_EXPIRE_LIMIT: prdata = {16'b0, limit_q};
			REG_DIST_CREEP:   prdata = {24'b0, creep_q};
			default:          prdata = '0;
		endcase
	end

	// The task count never passes the table size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("task count above table size");

	// Writes only touch valid slots or the next free one.
	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= cnt_q))
		else $error("table write beyond the valid region");

	// The task count only moves on an append.
	a_cnt_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> ($past(insert) && (cnt_q == $past(cnt_q) + 1'b1)))
		else $error("task count changed without an insert");

	// A dropped insert reports no change.
	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_out_q.table_full) |->
		(!res_out_q.was_inserted && !res_out_q.info_changed))
		else $error("full table result with change flags");

	// Aging write-backs happen only during a tick.
	a_age_state: assert property (@(posedge clk) disable iff (!arst_n)
		age_v_s2 |-> (state_q == ST_AGE))
		else $error("aging stage active outside a tick");

endmodule
